@@ sv/fohist_pkg.sv @@
// Shared types and constants for the flow orientation histogram.
package fohist_pkg;

    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int VECTOR_WIDTH_DEF = 16;

    localparam int NUM_BINS    = 9;
    localparam int BIN_W       = 4;
    localparam int BIN_COUNT_W = 16;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

    // compass sector codes, angle counter-clockwise from east
    localparam logic [BIN_W-1:0] BIN_E    = 4'd0;
    localparam logic [BIN_W-1:0] BIN_NE   = 4'd1;
    localparam logic [BIN_W-1:0] BIN_N    = 4'd2;
    localparam logic [BIN_W-1:0] BIN_NW   = 4'd3;
    localparam logic [BIN_W-1:0] BIN_W_   = 4'd4;
    localparam logic [BIN_W-1:0] BIN_SW   = 4'd5;
    localparam logic [BIN_W-1:0] BIN_S    = 4'd6;
    localparam logic [BIN_W-1:0] BIN_SE   = 4'd7;
    localparam logic [BIN_W-1:0] BIN_ZERO = 4'd8;

    // classified request passed from front to back
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             last;
    } t_bin_req;

    // queue head as seen by the back end
    typedef struct packed {
        t_bin_req req;
        logic     empty;
    } t_queue_head;

    typedef enum logic {
        ACC_RUN,
        ACC_READ
    } t_acc_state;

endpackage

@@ sv/flow_orientation_histogram.sv @@
// Top level of the flow orientation histogram: classifier, request queue and counter bank.
//
// Usage
//   Input: a flow vector (i_flow_x, i_flow_y, signed) and i_last_vector are taken at a
//   rising edge with start high and busy low. One vector a cycle is taken while the queue
//   has room; each is sorted into one of eight 45-degree compass sectors centred on east
//   (north is negative flow_y), or bin 8 for the zero vector, and counted in a saturating
//   counter.
//   Output: nothing for an ordinary vector. For a vector marked last, that vector is
//   counted and then nine results follow back to back, bins 0 to 8, each
//   with o_valid high for one cycle; o_last_bin marks bin 8. Each counter is cleared as
//   it is read out.
//   Path: a last vector passes the magnitude stage, the product stage, the queue
//   write and the counter update before the first result is on the ports.
//   Throughput: one vector a cycle while busy is low, set by the single counter update
//   port; every last vector holds that port for the readout, during which the eight-entry
//   queue fills and busy rises when queue level plus vectors in flight reach its depth.
//   The receiver cannot hold results off; they are shown once and not repeated.
//   Reset (synchronous, active low) clears all counters, the queue and the pipeline.
module flow_orientation_histogram #(
    parameter int COUNT_WIDTH  = fohist_pkg::COUNT_WIDTH_DEF,
    parameter int VECTOR_WIDTH = fohist_pkg::VECTOR_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [VECTOR_WIDTH-1:0]              i_flow_x,
    input  logic [VECTOR_WIDTH-1:0]              i_flow_y,
    input  logic                                 i_last_vector,
    output logic                                 o_valid,
    output logic [fohist_pkg::BIN_W-1:0]         o_bin_index,
    output logic [fohist_pkg::BIN_COUNT_W-1:0]   o_bin_count,
    output logic                                 o_last_bin
);

    logic                                w_accept;
    logic                                w_push;
    fohist_pkg::t_bin_req                w_req;
    logic [1:0]                          w_inflight;
    logic                                w_pop;
    fohist_pkg::t_queue_head             w_head;
    logic [fohist_pkg::QUEUE_LVL_W-1:0]  w_level;
    logic [fohist_pkg::QUEUE_LVL_W:0]    w_credit;

    // vectors in the pipeline already own a queue slot
    assign w_credit = {1'b0, w_level}
                    + {{(fohist_pkg::QUEUE_LVL_W-1){1'b0}}, w_inflight};
    assign busy     = w_credit >= (fohist_pkg::QUEUE_LVL_W+1)'(fohist_pkg::QUEUE_DEPTH);
    assign w_accept = start && !busy;

    fohist_classify #(
        .VECTOR_WIDTH (VECTOR_WIDTH)
    ) u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_flow_x      (i_flow_x),
        .i_flow_y      (i_flow_y),
        .i_last_vector (i_last_vector),
        .o_push        (w_push),
        .o_req         (w_req),
        .o_inflight    (w_inflight)
    );

    fohist_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_level (w_level)
    );

    fohist_accum #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_bin_index (o_bin_index),
        .o_bin_count (o_bin_count),
        .o_last_bin  (o_last_bin)
    );

endmodule

@@ sv/fohist_classify.sv @@
// Front end: magnitude, product and tangent-compare pipeline that sorts a vector into a sector.
module fohist_classify #(
    parameter int VECTOR_WIDTH = fohist_pkg::VECTOR_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [VECTOR_WIDTH-1:0]   i_flow_x,
    input  logic [VECTOR_WIDTH-1:0]   i_flow_y,
    input  logic                      i_last_vector,
    output logic                      o_push,
    output fohist_pkg::t_bin_req      o_req,
    output logic [1:0]                o_inflight
);

    localparam int PW = 2 * VECTOR_WIDTH;

    // stage 1: sign and magnitude
    logic                    r_v1;
    logic [VECTOR_WIDTH-1:0] r_a;
    logic [VECTOR_WIDTH-1:0] r_b;
    logic                    r_xneg1;
    logic                    r_yneg1;
    logic                    r_last1;

    // stage 2: products
    logic          r_v2;
    logic [PW-1:0] r_aa;
    logic [PW-1:0] r_bb;
    logic [PW-1:0] r_ab;
    logic          r_zero2;
    logic          r_xneg2;
    logic          r_npos2;
    logic          r_last2;

    logic [VECTOR_WIDTH-1:0] w_ax;
    logic [VECTOR_WIDTH-1:0] w_by;
    logic [PW:0]             w_sum_h;
    logic [PW:0]             w_sum_v;
    logic                    w_horiz;
    logic                    w_vert;

    // most negative value negates onto itself, which is the right unsigned magnitude
    assign w_ax = i_flow_x[VECTOR_WIDTH-1] ? (~i_flow_x + 1'b1) : i_flow_x;
    assign w_by = i_flow_y[VECTOR_WIDTH-1] ? (~i_flow_y + 1'b1) : i_flow_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= w_ax;
        r_b     <= w_by;
        r_xneg1 <= i_flow_x[VECTOR_WIDTH-1];
        r_yneg1 <= i_flow_y[VECTOR_WIDTH-1];
        r_last1 <= i_last_vector;

        r_aa    <= PW'(r_a) * PW'(r_a);
        r_bb    <= PW'(r_b) * PW'(r_b);
        r_ab    <= PW'(r_a) * PW'(r_b);
        r_zero2 <= (r_a == '0) && (r_b == '0);
        r_xneg2 <= r_xneg1;
        // north is up, so a negative flow_y points north
        r_npos2 <= r_yneg1 && (r_b != '0);
        r_last2 <= r_last1;
    end

    // b < a*tan(22.5)  <=>  b^2 + 2ab < a^2, and the mirror test for the vertical sectors
    assign w_sum_h = {1'b0, r_bb} + {r_ab, 1'b0};
    assign w_sum_v = {1'b0, r_aa} + {r_ab, 1'b0};
    assign w_horiz = w_sum_h < {1'b0, r_aa};
    assign w_vert  = w_sum_v < {1'b0, r_bb};

    always_comb begin
        o_req.last = r_last2;
        priority if (r_zero2) begin
            o_req.bin = fohist_pkg::BIN_ZERO;
        end else if (w_horiz) begin
            o_req.bin = r_xneg2 ? fohist_pkg::BIN_W_ : fohist_pkg::BIN_E;
        end else if (w_vert) begin
            o_req.bin = r_npos2 ? fohist_pkg::BIN_N : fohist_pkg::BIN_S;
        end else if (r_npos2) begin
            o_req.bin = r_xneg2 ? fohist_pkg::BIN_NW : fohist_pkg::BIN_NE;
        end else begin
            o_req.bin = r_xneg2 ? fohist_pkg::BIN_SW : fohist_pkg::BIN_SE;
        end
    end

    assign o_push     = r_v2;
    assign o_inflight = {1'b0, r_v1} + {1'b0, r_v2};

endmodule

@@ sv/fohist_queue.sv @@
// Short request queue between the classifier and the counter bank.
module fohist_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  fohist_pkg::t_bin_req                 i_req,
    input  logic                                 i_pop,
    output fohist_pkg::t_queue_head              o_head,
    output logic [fohist_pkg::QUEUE_LVL_W-1:0]   o_level
);

    fohist_pkg::t_bin_req r_mem [fohist_pkg::QUEUE_DEPTH];

    logic [fohist_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [fohist_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [fohist_pkg::QUEUE_LVL_W-1:0] r_level;
    logic [fohist_pkg::QUEUE_LVL_W-1:0] n_level;
    logic                               w_pop;

    assign w_pop = i_pop && (r_level != '0);

    always_comb begin
        n_level = r_level;
        unique case ({i_push, w_pop})
            2'b10:   n_level = r_level + 1'b1;
            2'b01:   n_level = r_level - 1'b1;
            default: n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_head.req   = r_mem[r_rd_ptr];
    assign o_head.empty = (r_level == '0);
    assign o_level      = r_level;

endmodule

@@ sv/fohist_accum.sv @@
// Back end: saturating bin counters and the readout of all nine bins on a last request.
module fohist_accum #(
    parameter int COUNT_WIDTH = fohist_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fohist_pkg::t_queue_head              i_head,
    output logic                                 o_pop,
    output logic                                 o_valid,
    output logic [fohist_pkg::BIN_W-1:0]         o_bin_index,
    output logic [fohist_pkg::BIN_COUNT_W-1:0]   o_bin_count,
    output logic                                 o_last_bin
);

    fohist_pkg::t_acc_state r_state;
    fohist_pkg::t_acc_state n_state;

    logic [COUNT_WIDTH-1:0]          r_cnt [fohist_pkg::NUM_BINS];
    logic [fohist_pkg::BIN_W-1:0]    r_idx;
    logic [fohist_pkg::BIN_W-1:0]    n_idx;
    logic [fohist_pkg::BIN_W-1:0]    w_addr;
    logic [COUNT_WIDTH-1:0]          w_rd;
    logic [COUNT_WIDTH-1:0]          w_wr;
    logic                            w_we;
    logic                            w_reading;
    logic [COUNT_WIDTH+fohist_pkg::BIN_COUNT_W-1:0] w_ext;

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            fohist_pkg::ACC_RUN: begin
                n_idx = '0;
                if (!i_head.empty && i_head.req.last) begin
                    n_state = fohist_pkg::ACC_READ;
                end
            end
            fohist_pkg::ACC_READ: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == fohist_pkg::BIN_ZERO) begin
                    n_state = fohist_pkg::ACC_RUN;
                end
            end
            default: begin
                n_state = fohist_pkg::ACC_RUN;
                n_idx   = '0;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_pop     = 1'b0;
        w_reading = 1'b0;
        unique case (r_state)
            fohist_pkg::ACC_RUN:  o_pop     = !i_head.empty;
            fohist_pkg::ACC_READ: w_reading = 1'b1;
            default: begin
                o_pop     = 1'b0;
                w_reading = 1'b0;
            end
        endcase
    end

    // one counter is touched per cycle: the popped bin, or the bin being read out
    assign w_addr = w_reading ? r_idx : i_head.req.bin;
    assign w_rd   = r_cnt[w_addr];
    assign w_we   = w_reading || o_pop;
    assign w_wr   = w_reading ? '0 : ((w_rd == '1) ? w_rd : w_rd + 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fohist_pkg::ACC_RUN;
            r_idx   <= '0;
            for (int i = 0; i < fohist_pkg::NUM_BINS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_we) begin
                r_cnt[w_addr] <= w_wr;
            end
        end
    end

    assign w_ext       = {{fohist_pkg::BIN_COUNT_W{1'b0}}, w_rd};
    assign o_valid     = w_reading;
    assign o_bin_index = r_idx;
    assign o_bin_count = w_ext[fohist_pkg::BIN_COUNT_W-1:0];
    assign o_last_bin  = w_reading && (r_idx == fohist_pkg::BIN_ZERO);

endmodule
